/* sv/fltr_pkg.sv */
// Shared types for the flow table last-seen tracker.
// Holds the stored entry layout and the control state encoding; no dependencies.
`default_nettype none

package fltr_pkg;

	// One stored flow: key (address, port) and last-seen time
	typedef struct packed {
		logic [31:0] addr;
		logic [15:0] port;
		logic [47:0] seen;
	} fltr_entry_t;

	// Control sequencer states, one-hot
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SCAN = 5'b00010,
		S_MISS = 5'b00100,
		S_READ = 5'b01000,
		S_OUT  = 5'b10000
	} fltr_state_t;

endpackage

`default_nettype wire

/* sv/fltr_ram.sv */
// Flow table storage: one write port, one read port, registered read data.
// Depends on fltr_pkg for the entry layout.
`default_nettype none

module fltr_ram
	import fltr_pkg::*;
#(
	parameter int DEPTH = 512,
	parameter int AW    = 9
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire fltr_entry_t   wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output fltr_entry_t        rd_data
);

	fltr_entry_t mem [DEPTH];

	// write port and registered read port; contents undefined until written
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* sv/flow_table_last_seen_tracker.sv */
// Flow table last-seen tracker: top level with sequencer, counters and result registers.
// Depends on fltr_pkg and instantiates fltr_ram.
//
// Usage:
//   Issue a command by raising start while busy is low; the fields are taken at that edge.
//   cmd 0 is a packet beat: the table is searched in insertion order, one entry per cycle
//   out of the synchronous table memory. A hit refreshes that entry's last-seen time; a miss
//   appends a new entry, or reports table_full when all FLOW_ENTRIES slots are used.
//   cmd 1 reads one entry; entries at or beyond the flow count read as zero.
//   The result is shown for exactly one cycle with done high; the receiver cannot stall it.
// Sequence: a packet scans the stored flows in order, if there are any, then on a miss
// passes through the miss step; a zero-size packet skips both and changes nothing.
// A read in range passes through one table read; one out of range goes straight to the result.
// The scan over the stored flows through the single memory read port sets the rate,
// so one command is in flight at a time.
// Reset clears the flow count and byte total; table contents need no clearing because
// only entries below the flow count are ever read.
`default_nettype none

module flow_table_last_seen_tracker
	import fltr_pkg::*;
#(
	parameter int FLOW_ENTRIES = 512
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        cmd,
	input  wire logic [31:0] src_addr,
	input  wire logic [15:0] src_port,
	input  wire logic [15:0] packet_bytes,
	input  wire logic [47:0] now_time,
	input  wire logic [8:0]  entry_index,
	output logic             done,
	output logic [8:0]       flow_index,
	output logic             new_flow,
	output logic             table_full,
	output logic [9:0]       flow_count,
	output logic [47:0]      total_bytes,
	output logic [31:0]      entry_addr,
	output logic [15:0]      entry_port,
	output logic [47:0]      entry_time
);

	localparam int IW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
	localparam int CW = $clog2(FLOW_ENTRIES + 1);

	fltr_state_t     state_q;
	logic [IW-1:0]   ptr_q;
	logic [CW-1:0]   stored_q;
	logic [47:0]     total_q;
	logic [31:0]     key_addr_q;
	logic [15:0]     key_port_q;
	logic [47:0]     now_q;
	logic [15:0]     bytes_q;
	logic [8:0]      fidx_q;
	logic            new_q;
	logic            full_q;
	logic [31:0]     eaddr_q;
	logic [15:0]     eport_q;
	logic [47:0]     etime_q;

	logic            accept;
	logic            idx_valid;
	logic            hit;
	logic            more;
	logic            has_room;
	logic            rd_en;
	logic [IW-1:0]   rd_addr;
	fltr_entry_t     rd_data;
	logic            wr_en;
	logic [IW-1:0]   wr_addr;
	fltr_entry_t     wr_data;

	assign busy       = (state_q != S_IDLE);
	assign accept     = start && !busy;
	assign done       = (state_q == S_OUT);
	assign flow_index = fidx_q;
	assign new_flow   = new_q;
	assign table_full = full_q;
	assign flow_count = 10'(stored_q);
	assign total_bytes = total_q;
	assign entry_addr = eaddr_q;
	assign entry_port = eport_q;
	assign entry_time = etime_q;

	// search and range decisions
	assign idx_valid = (13'(entry_index) < 13'(stored_q));
	assign hit       = (rd_data.addr == key_addr_q) && (rd_data.port == key_port_q);
	assign more      = ((CW'(ptr_q) + CW'(1)) < stored_q);
	assign has_room  = (stored_q < CW'(FLOW_ENTRIES));

	// table memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = ptr_q;
		wr_en   = 1'b0;
		wr_addr = ptr_q;
		wr_data = '{addr: key_addr_q, port: key_port_q, seen: now_q};
		case (state_q)
			S_IDLE: begin
				if (accept && cmd && idx_valid) begin
					rd_en   = 1'b1;
					rd_addr = IW'(entry_index);
				end else if (accept && !cmd && (packet_bytes != 16'd0) && (stored_q != '0)) begin
					rd_en   = 1'b1;
					rd_addr = '0;
				end
			end
			S_SCAN: begin
				if (hit) begin
					wr_en = 1'b1;
				end else if (more) begin
					rd_en   = 1'b1;
					rd_addr = ptr_q + IW'(1);
				end
			end
			S_MISS: begin
				if (has_room) begin
					wr_en   = 1'b1;
					wr_addr = IW'(stored_q);
				end
			end
			default: begin
			end
		endcase
	end

	fltr_ram #(
		.DEPTH (FLOW_ENTRIES),
		.AW    (IW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// command latch, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			key_addr_q <= src_addr;
			key_port_q <= src_port;
			now_q      <= now_time;
			bytes_q    <= packet_bytes;
		end
	end

	// sequencer, counters and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ptr_q    <= '0;
			stored_q <= '0;
			total_q  <= '0;
			fidx_q   <= '0;
			new_q    <= 1'b0;
			full_q   <= 1'b0;
			eaddr_q  <= '0;
			eport_q  <= '0;
			etime_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						fidx_q  <= '0;
						new_q   <= 1'b0;
						full_q  <= 1'b0;
						eaddr_q <= '0;
						eport_q <= '0;
						etime_q <= '0;
						ptr_q   <= '0;
						if (cmd) begin
							state_q <= idx_valid ? S_READ : S_OUT;
						end else if (packet_bytes == 16'd0) begin
							state_q <= S_OUT;
						end else if (stored_q == '0) begin
							state_q <= S_MISS;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// compare the entry fetched last cycle
					if (hit) begin
						fidx_q  <= 9'(ptr_q);
						total_q <= total_q + 48'(bytes_q);
						state_q <= S_OUT;
					end else if (more) begin
						ptr_q <= ptr_q + IW'(1);
					end else begin
						state_q <= S_MISS;
					end
				end
				S_MISS: begin
					total_q <= total_q + 48'(bytes_q);
					if (has_room) begin
						fidx_q   <= 9'(stored_q);
						new_q    <= 1'b1;
						stored_q <= stored_q + CW'(1);
					end else begin
						full_q <= 1'b1;
					end
					state_q <= S_OUT;
				end
				S_READ: begin
					eaddr_q <= rd_data.addr;
					eport_q <= rd_data.port;
					etime_q <= rd_data.seen;
					state_q <= S_OUT;
				end
				S_OUT: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// flow count never passes the table size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		13'(stored_q) <= 13'(FLOW_ENTRIES))
		else $error("flow count exceeds table size");

	// scan pointer stays inside the stored flows
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (CW'(ptr_q) < stored_q))
		else $error("scan pointer beyond stored flows");

	// count grows only by one, together with a new-flow result
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(stored_q != $past(stored_q)) |->
			((stored_q == $past(stored_q) + CW'(1)) && done && new_q))
		else $error("flow count changed without a new flow");

	// a result never claims both insertion and a full table
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(new_q && full_q))
		else $error("new_flow and table_full both set");

	// strobe lasts one cycle and the block is free again after it
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!done && !busy))
		else $error("result strobe longer than one cycle");
`endif

endmodule

`default_nettype wire
